>>> design/tpbpsa_pkg.sv
// ----------------------------------------------------------------------------
// tpbpsa_pkg: shared types and codes for the two-pool slot allocator
// Address width, request kinds and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tpbpsa_pkg;

  localparam int ADDR_W   = 48;
  localparam int STATUS_W = 2;

  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Request kinds.
  localparam logic KIND_MAP   = 1'b0;
  localparam logic KIND_UNMAP = 1'b1;

  // Result status codes.
  localparam status_t STATUS_OK            = 2'd0;
  localparam status_t STATUS_FULL          = 2'd1;
  localparam status_t STATUS_OUT_OF_WINDOW = 2'd2;

endpackage

`default_nettype wire

>>> design/two_pool_bitmap_page_slot_allocator.sv
// ----------------------------------------------------------------------------
// two_pool_bitmap_page_slot_allocator
// First-fit slot allocator for a mapping window split into a small-page half
// and a large-page half, with one used bit per slot kept in a word memory.
// ----------------------------------------------------------------------------
// Both pools live in one memory of 64-bit words (narrower when the small pool
// has fewer than 64 slots): the small pool's rows come first, then the large
// pool's. A map word walks the chosen pool one row per cycle through the
// single read port and the lowest-zero finder. An unmap word subtracts the
// base, reads the row, writes it back and loads the result; an address
// outside the window skips the read and the write. After reset a clearing
// pass writes zero to every row, one row a cycle, and no word is accepted
// until it ends. Configuration writes are taken in every cycle.
`default_nettype none

module two_pool_bitmap_page_slot_allocator
  import tpbpsa_pkg::*;
#(
  parameter int HALF_WINDOW_LOG2 = 24,
  parameter int SMALL_PAGE_LOG2  = 12,
  parameter int LARGE_PAGE_LOG2  = 21
) (
  input  wire logic           clk,
  input  wire logic           rst_n,

  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire addr_t          cfg_window_base,

  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           in_kind,
  input  wire logic           in_large_page,
  input  wire addr_t          in_address,

  output logic                out_valid,
  input  wire logic           out_ready,
  output addr_t               out_mapped_address,
  output status_t             out_status
);

  // Geometry of the two pools.
  localparam int SMALL_SH = HALF_WINDOW_LOG2 - SMALL_PAGE_LOG2;
  localparam bit LARGE_OK = (HALF_WINDOW_LOG2 >= LARGE_PAGE_LOG2);
  localparam int LARGE_SH = LARGE_OK ? (HALF_WINDOW_LOG2 - LARGE_PAGE_LOG2) : 0;
  localparam int WW_LOG2  = (SMALL_SH < 6) ? SMALL_SH : 6;
  localparam int WW       = 1 << WW_LOG2;
  localparam int SMALL_ROWS = 1 << (SMALL_SH - WW_LOG2);
  localparam int LARGE_ROWS = (LARGE_SH > WW_LOG2) ? (1 << (LARGE_SH - WW_LOG2)) : 1;
  localparam int TOTAL_ROWS = SMALL_ROWS + LARGE_ROWS;
  localparam int ROW_AW     = $clog2(TOTAL_ROWS);
  localparam int SLOT_W     = SMALL_SH;

  // Bits of the large pool's row that hold real slots; the rest read as used.
  localparam int LARGE_ROW_BITS =
    LARGE_OK ? ((LARGE_SH >= WW_LOG2) ? WW : (1 << LARGE_SH)) : 0;
  localparam logic [WW:0] LARGE_LIVE =
    ((WW+1)'(1) << LARGE_ROW_BITS) - (WW+1)'(1);
  localparam logic [WW-1:0] LARGE_PAD = ~LARGE_LIVE[WW-1:0];

  localparam logic [ROW_AW-1:0] SMALL_LAST  = ROW_AW'(SMALL_ROWS - 1);
  localparam logic [ROW_AW-1:0] LARGE_FIRST = ROW_AW'(SMALL_ROWS);
  localparam logic [ROW_AW-1:0] ROW_LAST    = ROW_AW'(TOTAL_ROWS - 1);

  localparam addr_t HALF_SIZE = ADDR_W'(64'd1 << HALF_WINDOW_LOG2);

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR     = 3'd0;
  localparam logic [2:0] ST_IDLE      = 3'd1;
  localparam logic [2:0] ST_SCAN      = 3'd2;
  localparam logic [2:0] ST_UNMAP_CHK = 3'd3;
  localparam logic [2:0] ST_UNMAP_WR  = 3'd4;
  localparam logic [2:0] ST_DONE      = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [ROW_AW-1:0] row_r, row_nxt;
  logic              kind_r, kind_nxt;
  logic              large_r, large_nxt;
  addr_t             off_r, off_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  status_t           res_status_r, res_status_nxt;
  addr_t             window_base_r;

  logic              out_valid_r, out_valid_nxt;
  addr_t             out_addr_r, out_addr_nxt;
  status_t           out_status_r, out_status_nxt;

  // Bitmap memory.
  logic [WW-1:0]     mem [TOTAL_ROWS];
  logic [WW-1:0]     rd_data_r;
  logic              wr_en;
  logic [WW-1:0]     wr_data;

  // Scan datapath.
  logic [WW-1:0]       scan_word;
  logic                scan_hit;
  logic [WW_LOG2-1:0]  scan_bit;
  logic [ROW_AW-1:0]   local_row;

  // Unmap datapath.
  logic [HALF_WINDOW_LOG2-1:0] in_half_off;
  logic                        upper_half;
  logic [SLOT_W-1:0]           unmap_slot;
  logic [ROW_AW-1:0]           unmap_row;

  logic  out_free;
  addr_t map_off;

  assign cfg_ready          = 1'b1;
  assign in_ready           = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_mapped_address = out_addr_r;
  assign out_status         = out_status_r;
  assign out_free           = !out_valid_r || out_ready;

  // Lowest free bit of the current row; padding bits of the large row count as used.
  always_comb begin
    scan_word = rd_data_r | (large_r ? LARGE_PAD : '0);
    scan_hit  = ~&scan_word;
    scan_bit  = '0;
    for (int i = WW - 1; i >= 0; i--) begin
      if (!scan_word[i]) begin
        scan_bit = WW_LOG2'(i);
      end
    end
  end

  assign local_row = row_r - (large_r ? LARGE_FIRST : ROW_AW'(0));

  assign in_half_off = off_r[HALF_WINDOW_LOG2-1:0];
  assign upper_half  = off_r[HALF_WINDOW_LOG2];
  assign unmap_slot  = upper_half ? SLOT_W'(in_half_off >> LARGE_PAGE_LOG2)
                                  : SLOT_W'(in_half_off >> SMALL_PAGE_LOG2);
  assign unmap_row   = ROW_AW'(unmap_slot >> WW_LOG2)
                     + (upper_half ? LARGE_FIRST : ROW_AW'(0));

  assign map_off = large_r ? (HALF_SIZE | (ADDR_W'(slot_r) << LARGE_PAGE_LOG2))
                           : (ADDR_W'(slot_r) << SMALL_PAGE_LOG2);

  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    kind_nxt       = kind_r;
    large_nxt      = large_r;
    off_nxt        = off_r;
    slot_nxt       = slot_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    wr_en          = 1'b0;
    wr_data        = '0;

    unique case (state_r)
      ST_CLEAR: begin
        wr_en = 1'b1;
        if (row_r == ROW_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          row_nxt = row_r + ROW_AW'(1);
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          large_nxt = in_large_page;
          if (in_kind == KIND_MAP) begin
            row_nxt   = in_large_page ? LARGE_FIRST : ROW_AW'(0);
            state_nxt = ST_SCAN;
          end else begin
            off_nxt   = in_address - window_base_r;
            state_nxt = ST_UNMAP_CHK;
          end
        end
      end

      // rd_data_r holds the row at row_r in every cycle of this state.
      ST_SCAN: begin
        if (scan_hit) begin
          wr_en          = 1'b1;
          wr_data        = rd_data_r | (WW'(1) << scan_bit);
          slot_nxt       = (SLOT_W'(local_row) << WW_LOG2) | SLOT_W'(scan_bit);
          res_status_nxt = STATUS_OK;
          state_nxt      = ST_DONE;
        end else if (row_r == (large_r ? ROW_LAST : SMALL_LAST)) begin
          res_status_nxt = STATUS_FULL;
          state_nxt      = ST_DONE;
        end else begin
          row_nxt = row_r + ROW_AW'(1);
        end
      end

      ST_UNMAP_CHK: begin
        res_status_nxt = STATUS_OK;
        if (|off_r[ADDR_W-1:HALF_WINDOW_LOG2+1]) begin
          res_status_nxt = STATUS_OUT_OF_WINDOW;
          state_nxt      = ST_DONE;
        end else if (upper_half && !LARGE_OK) begin
          // The large half has no slots, so there is nothing to free.
          state_nxt = ST_DONE;
        end else begin
          slot_nxt  = unmap_slot;
          row_nxt   = unmap_row;
          state_nxt = ST_UNMAP_WR;
        end
      end

      ST_UNMAP_WR: begin
        wr_en     = 1'b1;
        wr_data   = rd_data_r & ~(WW'(1) << slot_r[WW_LOG2-1:0]);
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          if (kind_r == KIND_MAP && res_status_r == STATUS_OK) begin
            out_addr_nxt = window_base_r + map_off;
          end else begin
            out_addr_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The read address follows the next row, so the data lines up with row_r.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[row_r] <= wr_data;
    end
    rd_data_r <= mem[row_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      row_r         <= '0;
      out_valid_r   <= 1'b0;
      window_base_r <= '0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        window_base_r <= cfg_window_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    large_r      <= large_nxt;
    off_r        <= off_nxt;
    slot_r       <= slot_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("allocator took a second word while one was in flight");

  a_full_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_FULL) |-> (out_mapped_address == '0))
    else $error("full result carries a nonzero address");

  a_window_only_on_unmap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && res_status_r == STATUS_OUT_OF_WINDOW) |->
      (kind_r == KIND_UNMAP))
    else $error("window error reported for a map request");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_OK || out_status == STATUS_FULL ||
                   out_status == STATUS_OUT_OF_WINDOW))
    else $error("result carries an undefined status code");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result loaded outside the completion step");
`endif

endmodule

`default_nettype wire
